@@ sv/owm_pkg.sv @@
// Shared types, codes and timing constants of the 1-Wire bus master.
package owm_pkg;

    localparam int DUR_W     = 10;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    // Function codes of an input beat
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRES_SAMPLE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_REC   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_READ_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_READ_REC    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WR_ONE_LOW  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_WR_ZERO_LOW = 3'd7;

    // Reset values of the timing registers, in microseconds
    localparam logic [DUR_W-1:0] RST_RESET_LOW   = 10'd485;
    localparam logic [DUR_W-1:0] RST_PRES_SAMPLE = 10'd65;
    localparam logic [DUR_W-1:0] RST_RESET_REC   = 10'd500;
    localparam logic [DUR_W-1:0] RST_READ_LOW    = 10'd2;
    localparam logic [DUR_W-1:0] RST_READ_SAMPLE = 10'd13;
    localparam logic [DUR_W-1:0] RST_READ_REC    = 10'd45;
    localparam logic [DUR_W-1:0] RST_WR_ONE_LOW  = 10'd3;
    localparam logic [DUR_W-1:0] RST_WR_ZERO_LOW = 10'd65;
    localparam logic [DUR_W-1:0] WRITE_GAP_TIME  = 10'd5;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       line_level;
    } t_in_beat;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       no_presence;
        logic       rejected;
    } t_out_beat;

    // Classified item handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ sv/owm_front.sv @@
// Front stage: accepts input beats, classifies them and feeds the queue.
module owm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  owm_pkg::t_in_beat i_in_data,
    input  owm_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output owm_pkg::t_item    o_item
);
    import owm_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    assign o_push     = r_valid && !i_q_stat.full;
    assign o_in_ready = !r_valid || !i_q_stat.full;
    assign w_take     = i_in_valid && o_in_ready;
    assign o_item     = r_item;

    // Hold valid until the queue takes the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Classify and capture the beat
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.is_tick    <= (i_in_data.func == FUNC_TICK);
            r_item.func       <= i_in_data.func;
            r_item.data_byte  <= i_in_data.data_byte;
            r_item.line_level <= i_in_data.line_level;
        end
    end

endmodule

@@ sv/owm_queue.sv @@
// Short FIFO of classified items between front and back.
module owm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  owm_pkg::t_item   i_item,
    input  logic             i_pop,
    output owm_pkg::t_item   o_item,
    output owm_pkg::t_q_stat o_stat
);
    import owm_pkg::*;

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rd_ptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/owm_back.sv @@
// Back stage: timing registers, bus sequencer and the result register.
module owm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [owm_pkg::DUR_W-1:0]        i_cfg_data,
    input  owm_pkg::t_q_stat                 i_q_stat,
    input  owm_pkg::t_item                   i_item,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output owm_pkg::t_out_beat               o_out_data
);
    import owm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
        PH_RD_LOW, PH_RD_WAIT, PH_RD_REC,
        PH_WR_LOW, PH_WR_HIGH, PH_WR_GAP
    } t_phase;

    logic [DUR_W-1:0] r_cfg [NUM_REGS];

    t_phase           r_phase, n_phase;
    logic [DUR_W-1:0] r_count, n_count;
    logic [2:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic [7:0]       r_last_read, n_last_read;
    logic             r_absent, n_absent;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;

    logic [DUR_W-1:0] w_dur;
    logic [DUR_W:0]   w_count_inc;
    logic             w_end;
    logic             w_cur_bit;
    logic             w_done;
    logic             w_rej;

    assign o_pop       = !i_q_stat.empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Timing register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_RESET_LOW]   <= RST_RESET_LOW;
            r_cfg[REG_PRES_SAMPLE] <= RST_PRES_SAMPLE;
            r_cfg[REG_RESET_REC]   <= RST_RESET_REC;
            r_cfg[REG_READ_LOW]    <= RST_READ_LOW;
            r_cfg[REG_READ_SAMPLE] <= RST_READ_SAMPLE;
            r_cfg[REG_READ_REC]    <= RST_READ_REC;
            r_cfg[REG_WR_ONE_LOW]  <= RST_WR_ONE_LOW;
            r_cfg[REG_WR_ZERO_LOW] <= RST_WR_ZERO_LOW;
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_index[$clog2(NUM_REGS)-1:0]] <= i_cfg_data;
        end
    end

    // Pick the duration of the running phase
    assign w_cur_bit = r_shift[r_bit];
    always_comb begin
        case (r_phase)
            PH_RST_LOW:  w_dur = r_cfg[REG_RESET_LOW];
            PH_RST_WAIT: w_dur = r_cfg[REG_PRES_SAMPLE];
            PH_RST_REC:  w_dur = r_cfg[REG_RESET_REC];
            PH_RD_LOW:   w_dur = r_cfg[REG_READ_LOW];
            PH_RD_WAIT:  w_dur = r_cfg[REG_READ_SAMPLE];
            PH_RD_REC:   w_dur = r_cfg[REG_READ_REC];
            PH_WR_LOW:   w_dur = w_cur_bit ? r_cfg[REG_WR_ONE_LOW] : r_cfg[REG_WR_ZERO_LOW];
            PH_WR_HIGH:  w_dur = w_cur_bit ? r_cfg[REG_WR_ZERO_LOW] : r_cfg[REG_WR_ONE_LOW];
            PH_WR_GAP:   w_dur = WRITE_GAP_TIME;
            default:     w_dur = DUR_W'(1);
        endcase
    end

    // A zero duration ends on the first tick, like one
    assign w_count_inc = {1'b0, r_count} + 1'b1;
    assign w_end       = (w_count_inc >= {1'b0, w_dur});

    // Sequencer next state for the popped item
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_last_read = r_last_read;
        n_absent    = r_absent;
        w_done      = 1'b0;
        w_rej       = 1'b0;
        if (i_item.is_tick) begin
            if (r_phase != PH_IDLE) begin
                if (!w_end) begin
                    n_count = w_count_inc[DUR_W-1:0];
                end else begin
                    n_count = '0;
                    case (r_phase)
                        PH_RST_LOW:  n_phase = PH_RST_WAIT;
                        PH_RST_WAIT: begin
                            n_absent = i_item.line_level;
                            n_phase  = PH_RST_REC;
                        end
                        PH_RST_REC: begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end
                        PH_RD_LOW:   n_phase = PH_RD_WAIT;
                        PH_RD_WAIT: begin
                            n_shift[r_bit] = r_shift[r_bit] | i_item.line_level;
                            n_phase        = PH_RD_REC;
                        end
                        PH_RD_REC: begin
                            if (r_bit == 3'd7) begin
                                n_last_read = r_shift;
                                n_phase     = PH_IDLE;
                                w_done      = 1'b1;
                            end else begin
                                n_bit   = r_bit + 1'b1;
                                n_phase = PH_RD_LOW;
                            end
                        end
                        PH_WR_LOW:   n_phase = PH_WR_HIGH;
                        PH_WR_HIGH:  n_phase = PH_WR_GAP;
                        PH_WR_GAP: begin
                            if (r_bit == 3'd7) begin
                                n_phase = PH_IDLE;
                                w_done  = 1'b1;
                            end else begin
                                n_bit   = r_bit + 1'b1;
                                n_phase = PH_WR_LOW;
                            end
                        end
                        default:     n_phase = PH_IDLE;
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            w_rej = 1'b1;
        end else begin
            n_count = '0;
            n_bit   = '0;
            case (i_item.func)
                FUNC_RESET: n_phase = PH_RST_LOW;
                FUNC_WRITE: begin
                    n_shift = i_item.data_byte;
                    n_phase = PH_WR_LOW;
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_RD_LOW;
                end
            endcase
        end
    end

    // Build the result beat and its valid
    always_comb begin
        n_out.drive_low   = (n_phase == PH_RST_LOW) || (n_phase == PH_RD_LOW) ||
                            (n_phase == PH_WR_LOW);
        n_out.busy_res    = (n_phase != PH_IDLE);
        n_out.done_res    = w_done;
        n_out.read_byte   = n_last_read;
        n_out.no_presence = n_absent;
        n_out.rejected    = w_rej;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold state and the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_last_read <= '0;
            r_absent    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_last_read <= n_last_read;
                r_absent    <= n_absent;
            end
        end
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

@@ sv/onewire_bus_master_unit.sv @@
// Top level of the 1-Wire bus master: front stage, item queue and sequencer.
//
// Every input beat (a one-microsecond tick or a reset/write/read command)
// yields exactly one result beat. While the output is not stalled, the block
// sustains one beat per clock: the front register, a four-entry queue and the
// back sequencer each take one item per cycle, and the phase counter does one
// increment and compare per tick. A result beat passes the front register,
// the queue and the result register. Input and output stall on their own;
// the queue absorbs a stalled output for a few beats before input ready drops.
// Timing registers are to be written through the plain write port while no
// beat is in flight (not enforced here); indexes above seven are ignored.
module onewire_bus_master_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  owm_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output owm_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [owm_pkg::DUR_W-1:0]     i_cfg_data
);
    import owm_pkg::*;

    t_q_stat w_q_stat;
    t_item   w_front_item;
    t_item   w_head_item;
    logic    w_push;
    logic    w_pop;

    owm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    owm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_q_stat)
    );

    owm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (w_q_stat),
        .i_item      (w_head_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/owm_checker.sv @@
// Port-level checks of the 1-Wire bus master and their binding.
module owm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  owm_pkg::t_in_beat             i_in_data,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  owm_pkg::t_out_beat            o_out_data
);
    import owm_pkg::*;

    // Stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while stalled");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Line is only driven during an operation
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.drive_low |-> o_out_data.busy_res)
        else $error("drive_low without busy");

    // A finishing beat leaves the master idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res &&
        !o_out_data.rejected)
        else $error("done beat still busy or rejected");

    // A rejected command only happens while busy
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rejected |-> o_out_data.busy_res)
        else $error("rejected while idle");

endmodule

bind onewire_bus_master_unit owm_checker u_owm_checker (.*);
